[src/b64e_pkg.sv]
// Shared types, character codes and the alphabet lookup for the Base64 stream encoder.
// No dependencies.
package b64e_pkg;

    localparam logic [7:0] CHAR_CR  = 8'd13;
    localparam logic [7:0] CHAR_LF  = 8'd10;
    localparam logic [7:0] CHAR_PAD = 8'd61;

    localparam logic [5:0] GPL_RESET = 6'd19;

    // One three-byte group handed from the front to the back.
    typedef struct packed {
        logic [23:0] word;    // zero-padded group, first byte in the top
        logic [1:0]  nbytes;  // real bytes in the group, 1..3
        logic        crlf;    // line break goes ahead of the group
        logic        last;    // group closes the message
    } b64e_group_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        c = {2'b00, v};
        if (v < 6'd26)
            return c + 8'd65;
        else if (v < 6'd52)
            return c + 8'd71;   // 'a' - 26
        else if (v < 6'd62)
            return c - 8'd4;    // '0' - 52
        else if (v == 6'd62)
            return 8'd43;       // '+'
        else
            return 8'd47;       // '/'
    endfunction

endpackage

[src/b64e_front.sv]
// Input side: gathers bytes into groups and decides where line breaks fall.
// Depends on b64e_pkg.
module b64e_front
    import b64e_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    input  logic [5:0]  groups_per_line,
    input  logic        q_full,
    output logic        q_push,
    output b64e_group_t q_data
);

    logic [15:0] held_reg, held_next;
    logic [1:0]  nheld_reg, nheld_next;
    logic [5:0]  gil_reg, gil_next;
    logic        sent_reg, sent_next;

    logic [1:0]  nbytes;
    logic        take;
    logic        completes;
    logic        brk;
    logic [5:0]  gil_base;

    assign in_ready  = !q_full;
    assign take      = in_valid && in_ready;
    assign nbytes    = nheld_reg + 2'd1;
    assign completes = (nbytes == 2'd3) || final_byte;
    assign brk       = (groups_per_line != 6'd0) && sent_reg && (gil_reg >= groups_per_line);
    assign gil_base  = brk ? 6'd0 : gil_reg;
    assign q_push    = take && completes;

    always_comb
    begin
        case (nbytes)
            2'd1:    q_data.word = {data_byte, 16'h0000};
            2'd2:    q_data.word = {held_reg[7:0], data_byte, 8'h00};
            default: q_data.word = {held_reg, data_byte};
        endcase
        q_data.nbytes = nbytes;
        q_data.crlf   = brk;
        q_data.last   = final_byte;
    end

    always_comb
    begin
        held_next  = held_reg;
        nheld_next = nheld_reg;
        gil_next   = gil_reg;
        sent_next  = sent_reg;
        if (take)
        begin
            if (!completes)
            begin
                held_next  = {held_reg[7:0], data_byte};
                nheld_next = nbytes;
            end
            else if (final_byte)
            begin
                held_next  = 16'h0000;
                nheld_next = 2'd0;
                gil_next   = 6'd0;
                sent_next  = 1'b0;
            end
            else
            begin
                held_next  = 16'h0000;
                nheld_next = 2'd0;
                sent_next  = 1'b1;
                gil_next   = (groups_per_line != 6'd0) ? gil_base + 6'd1 : 6'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= 16'h0000;
            nheld_reg <= 2'd0;
            gil_reg   <= 6'd0;
            sent_reg  <= 1'b0;
        end
        else
        begin
            held_reg  <= held_next;
            nheld_reg <= nheld_next;
            gil_reg   <= gil_next;
            sent_reg  <= sent_next;
        end
    end

endmodule

[src/b64e_queue.sv]
// Short group queue between the front and the back.
// Depends on b64e_pkg.
module b64e_queue
    import b64e_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  b64e_group_t push_data,
    output logic        full,
    input  logic        pop,
    output logic        valid,
    output b64e_group_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64e_group_t        mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[src/b64e_back.sv]
// Output side: per group, CR LF on a break, four characters; one per cycle if ready.
// Depends on b64e_pkg.
module b64e_back
    import b64e_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  b64e_group_t q_head,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_char,
    output logic        out_last
);

    typedef enum logic [5:0] {
        STEP_CR  = 6'b000001,
        STEP_LF  = 6'b000010,
        STEP_CH0 = 6'b000100,
        STEP_CH1 = 6'b001000,
        STEP_CH2 = 6'b010000,
        STEP_CH3 = 6'b100000
    } step_t;

    b64e_group_t grp_reg, grp_next;
    logic        busy_reg, busy_next;
    step_t       step_reg, step_next;
    logic        ov_reg, ov_next;
    logic [7:0]  char_reg, char_next;
    logic        last_reg, last_next;

    logic        emit;
    logic        end_step;
    step_t       step_succ;
    logic [1:0]  idx;
    logic [5:0]  sextet;
    logic [7:0]  ch;

    assign emit     = busy_reg && (!ov_reg || out_ready);
    assign end_step = (step_reg == STEP_CH3);
    assign q_pop    = q_valid && (!busy_reg || (emit && end_step));

    always_comb
    begin
        case (step_reg)
            STEP_CR:  step_succ = STEP_LF;
            STEP_LF:  step_succ = STEP_CH0;
            STEP_CH0: step_succ = STEP_CH1;
            STEP_CH1: step_succ = STEP_CH2;
            default:  step_succ = STEP_CH3;
        endcase
        case (step_reg)
            STEP_CH1: idx = 2'd1;
            STEP_CH2: idx = 2'd2;
            STEP_CH3: idx = 2'd3;
            default:  idx = 2'd0;
        endcase
        case (idx)
            2'd0:    sextet = grp_reg.word[23:18];
            2'd1:    sextet = grp_reg.word[17:12];
            2'd2:    sextet = grp_reg.word[11:6];
            default: sextet = grp_reg.word[5:0];
        endcase
        case (step_reg)
            STEP_CR: ch = CHAR_CR;
            STEP_LF: ch = CHAR_LF;
            default: ch = (idx > grp_reg.nbytes) ? CHAR_PAD : b64_char(sextet);
        endcase
    end

    always_comb
    begin
        grp_next  = grp_reg;
        busy_next = busy_reg;
        step_next = step_reg;
        ov_next   = ov_reg;
        char_next = char_reg;
        last_next = last_reg;

        if (emit)
        begin
            ov_next   = 1'b1;
            char_next = ch;
            last_next = grp_reg.last && end_step;
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end

        if (q_pop)
        begin
            grp_next  = q_head;
            busy_next = 1'b1;
            step_next = q_head.crlf ? STEP_CR : STEP_CH0;
        end
        else if (emit && end_step)
        begin
            busy_next = 1'b0;
        end
        else if (emit)
        begin
            step_next = step_succ;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg  <= grp_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= STEP_CR;
            ov_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            ov_reg   <= ov_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

[src/base64_stream_encoder.sv]
// Base64 stream encoder with MIME line wrapping: one input byte per request, one output
// character per request. Bytes are taken one per cycle while the group queue has room;
// the output side sends one character per cycle while out_ready allows, so sustained
// throughput is set by the output channel: four characters per three bytes, plus CR LF
// at each line break. Groups pass the queue and a group register; output is registered.
// groups_per_line (reset 19, 0 = no breaks) is written through cfg_wr_en/cfg_wr_data.
// Depends on b64e_pkg, b64e_front, b64e_queue, b64e_back.
module base64_stream_encoder
    import b64e_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [5:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       out_last
);

    logic [5:0]  gpl_reg;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_valid;
    b64e_group_t q_in;
    b64e_group_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gpl_reg <= GPL_RESET;
        else if (cfg_wr_en)
            gpl_reg <= cfg_wr_data;
    end

    b64e_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .final_byte      (final_byte),
        .groups_per_line (gpl_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_data          (q_in)
    );

    b64e_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    b64e_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .out_last  (out_last)
    );

endmodule
